### sv/wsd_pkg.sv
// ============================================================================
// wsd_pkg: shared definitions for the WebSocket frame deframer
// Parser phase encoding, result status codes and field widths.
// ============================================================================
package wsd_pkg;

  // Field widths of one input byte and one result.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OP_W     = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STEP_W   = 2;
  localparam int unsigned KEY_N    = 4;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_OP    = 6'b000001,  // first header byte
    PH_LEN   = 6'b000010,  // mask flag and length code
    PH_EXT   = 6'b000100,  // 16-bit extended length
    PH_MASK  = 6'b001000,  // 4-byte mask key
    PH_DATA  = 6'b010000,  // payload bytes
    PH_DRAIN = 6'b100000   // trailing bytes up to the buffer end
  } phase_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_PAYLOAD = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_LONG    = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  // Length codes of the second header byte with special meaning.
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Index of the last mask key byte.
  localparam logic [STEP_W-1:0] KEY_LAST = STEP_W'(KEY_N - 1);

endpackage

### sv/websocket_frame_deframer_unit.sv
// ============================================================================
// websocket_frame_deframer_unit: byte-wide WebSocket frame parser
// A transfer is held in the input register, parsed, and its result is held in the
// result register. Throughput: one byte per cycle while the result stream does
// not stall; the parse step sits between the input register and the result register.
// Reset: synchronous, active low; the parser waits for a first header byte
// and both register stages come up empty. The mask key is not reset.
// ============================================================================
module websocket_frame_deframer_unit
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_end
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [14:8] frame_op, [15] zero
  output logic        out_tlast,  // out_final
  output logic [1:0]  out_tuser   // [1:0] status
);

  // Input register stage.
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_end_r;

  // Parser state.
  phase_t            phase_r, phase_nxt;
  logic [STEP_W-1:0] header_step_r, header_step_nxt;
  logic              masked_r, masked_nxt;
  logic [LEN_W-1:0]  payload_length_r, payload_length_nxt;
  logic [LEN_W-1:0]  payload_count_r, payload_count_nxt;
  logic [OP_W-1:0]   op_hold_r, op_hold_nxt;
  logic [BYTE_W-1:0] mask_key_r [KEY_N];

  // Result register stage.
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_final_r;
  logic [OP_W-1:0]   out_op_r;
  status_t           out_status_r;

  // Step outputs.
  logic              emit;
  logic [BYTE_W-1:0] res_byte;
  logic              res_final;
  status_t           res_status;
  logic              key_we;
  logic              do_len;
  logic              do_hdr;
  logic              trunc;
  logic [BYTE_W-1:0] key_byte;

  // Handshake between the stages.
  logic out_free;
  logic proc_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign proc_fire = in_valid_r && out_free;
  assign in_tready = !in_valid_r || proc_fire;

  // Input register: holds one byte until the parse step takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  // Mask key byte for the current payload position.
  assign key_byte = mask_key_r[payload_count_r[STEP_W-1:0]];

  // Parse step for the byte in the input register.
  always_comb begin
    phase_nxt          = phase_r;
    header_step_nxt    = header_step_r;
    masked_nxt         = masked_r;
    payload_length_nxt = payload_length_r;
    payload_count_nxt  = payload_count_r;
    op_hold_nxt        = op_hold_r;
    emit               = 1'b0;
    res_byte           = '0;
    res_final          = 1'b0;
    res_status         = ST_PAYLOAD;
    key_we             = 1'b0;
    do_len             = 1'b0;
    do_hdr             = 1'b0;
    trunc              = 1'b0;

    unique case (phase_r)
      PH_OP: begin
        op_hold_nxt = in_byte_r[OP_W-1:0];
        if (in_end_r) begin
          trunc = 1'b1;
        end else begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        masked_nxt = in_byte_r[7];
        if (in_byte_r[6:0] == LEN_CODE_64) begin
          emit       = 1'b1;
          res_final  = 1'b1;
          res_status = ST_LONG;
          phase_nxt  = in_end_r ? PH_OP : PH_DRAIN;
        end else if (in_byte_r[6:0] == LEN_CODE_16) begin
          if (in_end_r) begin
            trunc = 1'b1;
          end else begin
            payload_length_nxt = '0;
            header_step_nxt    = '0;
            phase_nxt          = PH_EXT;
          end
        end else begin
          payload_length_nxt = LEN_W'(in_byte_r[6:0]);
          do_len             = 1'b1;
        end
      end
      PH_EXT: begin
        // Big-endian: shift the earlier byte up.
        payload_length_nxt = {payload_length_r[7:0], in_byte_r};
        if (header_step_r == '0) begin
          if (in_end_r) begin
            trunc = 1'b1;
          end else begin
            header_step_nxt = STEP_W'(1);
          end
        end else begin
          do_len = 1'b1;
        end
      end
      PH_MASK: begin
        key_we = 1'b1;
        if (header_step_r != KEY_LAST) begin
          if (in_end_r) begin
            trunc = 1'b1;
          end else begin
            header_step_nxt = header_step_r + STEP_W'(1);
          end
        end else begin
          do_hdr = 1'b1;
        end
      end
      PH_DATA: begin
        payload_count_nxt = payload_count_r + LEN_W'(1);
        if (payload_count_nxt >= payload_length_r) begin
          emit      = 1'b1;
          res_byte  = masked_r ? (in_byte_r ^ key_byte) : in_byte_r;
          res_final = 1'b1;
          phase_nxt = in_end_r ? PH_OP : PH_DRAIN;
        end else if (in_end_r) begin
          trunc = 1'b1;
        end else begin
          emit     = 1'b1;
          res_byte = masked_r ? (in_byte_r ^ key_byte) : in_byte_r;
        end
      end
      default: begin
        // Trailing bytes are dropped until the buffer ends.
        if (in_end_r) begin
          phase_nxt = PH_OP;
        end
      end
    endcase

    // Length known: the mask key follows (unless the buffer ends), or the header is complete.
    if (do_len) begin
      if (masked_nxt) begin
        if (in_end_r) begin
          trunc = 1'b1;
        end else begin
          header_step_nxt = '0;
          phase_nxt       = PH_MASK;
        end
      end else begin
        do_hdr = 1'b1;
      end
    end

    // Header complete: an empty message, a truncated frame, or on to the payload.
    if (do_hdr) begin
      if (payload_length_nxt == '0) begin
        emit       = 1'b1;
        res_final  = 1'b1;
        res_status = ST_EMPTY;
        phase_nxt  = in_end_r ? PH_OP : PH_DRAIN;
      end else if (in_end_r) begin
        trunc = 1'b1;
      end else begin
        payload_count_nxt = '0;
        phase_nxt         = PH_DATA;
      end
    end

    // The buffer ended before the frame did.
    if (trunc) begin
      emit       = 1'b1;
      res_byte   = '0;
      res_final  = 1'b1;
      res_status = ST_TRUNC;
      phase_nxt  = PH_OP;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_OP;
      header_step_r    <= '0;
      masked_r         <= 1'b0;
      payload_length_r <= '0;
      payload_count_r  <= '0;
      op_hold_r        <= '0;
    end else if (proc_fire) begin
      phase_r          <= phase_nxt;
      header_step_r    <= header_step_nxt;
      masked_r         <= masked_nxt;
      payload_length_r <= payload_length_nxt;
      payload_count_r  <= payload_count_nxt;
      op_hold_r        <= op_hold_nxt;
    end
  end

  // Mask key bytes, written in header order.
  always_ff @(posedge clk) begin
    if (proc_fire && key_we) begin
      mask_key_r[header_step_r] <= in_byte_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      out_byte_r   <= res_byte;
      out_final_r  <= res_final;
      out_op_r     <= op_hold_nxt;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_op_r, out_byte_r};
  assign out_tlast  = out_final_r;
  assign out_tuser  = out_status_r;

  // A result that is not a payload byte carries a zero byte and ends the frame.
  a_nonpayload_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_PAYLOAD) |-> (out_byte_r == '0) && out_final_r)
    else $error("non-payload result without final flag or with nonzero byte");

  // The end of a buffer always brings the parser back to the first header byte.
  a_end_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && in_end_r |=> phase_r == PH_OP)
    else $error("parser not waiting for a header byte after buffer end");

  // While payload is streaming, the count stays below the frame length.
  a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> payload_count_r < payload_length_r)
    else $error("payload count reached length while still in payload");

  // The extended length takes only two byte steps.
  a_ext_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EXT |-> header_step_r <= STEP_W'(1))
    else $error("extended length step out of range");

endmodule
